// File: rtl/bdlp_pkg.sv
// package for the button debouncer with long-press events
// types, codes and constants shared by all rtl files of the block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bdlp_pkg;

  // debounce window lengths
  localparam logic [7:0] SETTLE_ACTIVE_TICKS   = 8'd5;
  localparam logic [7:0] SETTLE_INACTIVE_TICKS = 8'd5;

  // run counters stop here
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] CFG_PRESSED_LEVEL    = 2'd0;
  localparam logic [1:0] CFG_RELEASE_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  // result event codes
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_LONG     = 2'd3
  } event_e;

  // what the debouncer reports for one tick
  typedef enum logic [2:0] {
    OC_QUIET   = 3'd0,
    OC_EDGE    = 3'd1,
    OC_CONFIRM = 3'd2,
    OC_ABANDON = 3'd3,
    OC_LONG    = 3'd4
  } outcome_e;

  // watch level update requested by the press state machine
  typedef struct packed {
    logic toggle;
    logic load;
  } watch_upd_t;

endpackage

`default_nettype wire

// File: rtl/bdlp_debounce.sv
// debounce window: watch level, settle flag, last sample and run counters
// depends on bdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdlp_debounce (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 sample_i,
  input  wire logic                 pressed_level_i,
  input  wire logic [7:0]           long_press_ticks_i,
  input  wire bdlp_pkg::watch_upd_t watch_upd_i,
  output bdlp_pkg::outcome_e        outcome_o
);

  logic       watch_level_q, watch_level_d;
  logic       settled_q, settled_d;
  logic       last_sample_q;
  logic [7:0] active_run_q, active_run_d;
  logic [7:0] inactive_run_q, inactive_run_d;
  logic [7:0] active_inc;
  logic [7:0] inactive_inc;

  assign active_inc   = (active_run_q == bdlp_pkg::COUNT_MAX) ? bdlp_pkg::COUNT_MAX
                                                               : active_run_q + 8'd1;
  assign inactive_inc = (inactive_run_q == bdlp_pkg::COUNT_MAX) ? bdlp_pkg::COUNT_MAX
                                                                 : inactive_run_q + 8'd1;

  always_comb begin
    outcome_o      = bdlp_pkg::OC_QUIET;
    settled_d      = settled_q;
    active_run_d   = active_run_q;
    inactive_run_d = inactive_run_q;
    if (settled_q) begin
      if (sample_i == watch_level_q && last_sample_q != watch_level_q) begin
        outcome_o      = bdlp_pkg::OC_EDGE;
        active_run_d   = '0;
        inactive_run_d = '0;
        settled_d      = 1'b0;
      end else if (sample_i != watch_level_q && watch_level_q != pressed_level_i) begin
        // steady hold while watching for the release edge
        inactive_run_d = '0;
        active_run_d   = active_inc;
        if (long_press_ticks_i != 8'd0 && active_inc >= long_press_ticks_i) begin
          active_run_d = '0;
          outcome_o    = bdlp_pkg::OC_LONG;
        end
      end
    end else if (sample_i == watch_level_q) begin
      inactive_run_d = '0;
      active_run_d   = active_inc;
      if (active_inc >= bdlp_pkg::SETTLE_ACTIVE_TICKS) begin
        settled_d = 1'b1;
        outcome_o = bdlp_pkg::OC_CONFIRM;
      end
    end else begin
      active_run_d   = '0;
      inactive_run_d = inactive_inc;
      if (inactive_inc >= bdlp_pkg::SETTLE_INACTIVE_TICKS) begin
        settled_d = 1'b1;
        outcome_o = bdlp_pkg::OC_ABANDON;
      end
    end
  end

  always_comb begin
    watch_level_d = watch_level_q;
    if (watch_upd_i.load) begin
      watch_level_d = pressed_level_i;
    end else if (watch_upd_i.toggle) begin
      watch_level_d = ~watch_level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watch_level_q  <= 1'b0;
      settled_q      <= 1'b1;
      last_sample_q  <= 1'b1;
      active_run_q   <= '0;
      inactive_run_q <= '0;
    end else if (step_i) begin
      watch_level_q  <= watch_level_d;
      settled_q      <= settled_d;
      last_sample_q  <= sample_i;
      active_run_q   <= active_run_d;
      inactive_run_q <= inactive_run_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdlp_fsm.sv
// released / pressed state machine, held tick counter and event coding
// depends on bdlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdlp_fsm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire bdlp_pkg::outcome_e  outcome_i,
  input  wire logic                release_enable_i,
  output bdlp_pkg::watch_upd_t     watch_upd_o,
  output bdlp_pkg::event_e         event_o,
  output logic [7:0]               duration_o,
  output logic                     pressed_o
);

  logic       in_pressed_q, in_pressed_d;
  logic [7:0] held_ticks_q, held_ticks_d;

  // next state
  always_comb begin
    in_pressed_d = in_pressed_q;
    held_ticks_d = held_ticks_q;
    if (!in_pressed_q) begin
      if (outcome_i == bdlp_pkg::OC_EDGE) begin
        in_pressed_d = 1'b1;
        held_ticks_d = '0;
      end
    end else begin
      unique case (outcome_i)
        bdlp_pkg::OC_QUIET: begin
          held_ticks_d = (held_ticks_q == bdlp_pkg::COUNT_MAX) ? bdlp_pkg::COUNT_MAX
                                                               : held_ticks_q + 8'd1;
        end
        bdlp_pkg::OC_ABANDON, bdlp_pkg::OC_EDGE: begin
          in_pressed_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    event_o            = bdlp_pkg::EV_NONE;
    duration_o         = '0;
    watch_upd_o.toggle = 1'b0;
    watch_upd_o.load   = 1'b0;
    if (!in_pressed_q) begin
      if (outcome_i == bdlp_pkg::OC_EDGE) begin
        event_o = bdlp_pkg::EV_PRESSED;
      end
    end else begin
      unique case (outcome_i)
        bdlp_pkg::OC_CONFIRM: watch_upd_o.toggle = 1'b1;
        bdlp_pkg::OC_ABANDON: watch_upd_o.load = 1'b1;
        bdlp_pkg::OC_EDGE: begin
          watch_upd_o.load = 1'b1;
          if (release_enable_i) begin
            event_o    = bdlp_pkg::EV_RELEASED;
            duration_o = held_ticks_q;
          end
        end
        bdlp_pkg::OC_LONG: event_o = bdlp_pkg::EV_LONG;
        default: begin
        end
      endcase
    end
  end

  assign pressed_o = in_pressed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pressed_q <= 1'b0;
      held_ticks_q <= '0;
    end else if (step_i) begin
      in_pressed_q <= in_pressed_d;
      held_ticks_q <= held_ticks_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/button_debounce_long_press_top.sv
// top level of the button debouncer with press, release and long-press events
// depends on bdlp_pkg, bdlp_debounce and bdlp_fsm
//
// usage
//   input channel: one transaction per sampling tick, carrying the raw pin
//   level. every tick yields exactly one result transaction with an event
//   code (none, pressed, released, long pressed), the held tick count on a
//   release and the pressed flag after that tick.
//   result register: the result of a tick is presented in the cycle after its input
//   transaction is accepted.
//   throughput: one tick per cycle. the debounce and state update is a
//   single pass of short logic feeding the state registers and the result
//   register; in_ready_o stays high while the result register is empty or
//   is being drained in the same cycle.
//   receiver stall: the result is held in the output register; the next
//   tick is taken only when that register frees up, so results are never
//   dropped or reordered.
//   reset: asynchronous, active low. clears the debounce state to released,
//   settled, with the last sample at the released level, and loads the
//   register defaults (pressed level 0, release reporting on, long press off).
//   configuration: plain write port, to be used only while the block is idle;
//   a change of pressed level affects only later comparisons.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_long_press_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  // tick input channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       pin_level_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      event_code_o,
  output logic [7:0]      press_duration_o,
  output logic            is_pressed_o
);

  // configuration registers
  logic       pressed_level_q;
  logic       release_enable_q;
  logic [7:0] long_press_ticks_q;

  // handshake
  logic step;
  logic out_valid_q;

  // core signals
  bdlp_pkg::outcome_e   outcome;
  bdlp_pkg::watch_upd_t watch_upd;
  bdlp_pkg::event_e     event_d;
  logic [7:0]           duration_d;
  logic                 pressed_d;

  // result register
  logic [1:0] event_code_q;
  logic [7:0] press_duration_q;
  logic       is_pressed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_level_q    <= 1'b0;
      release_enable_q   <= 1'b1;
      long_press_ticks_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdlp_pkg::CFG_PRESSED_LEVEL:    pressed_level_q    <= cfg_data_i[0];
        bdlp_pkg::CFG_RELEASE_ENABLE:   release_enable_q   <= cfg_data_i[0];
        bdlp_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data_i;
        default: begin
          // unused index, write is ignored
        end
      endcase
    end
  end

  // accept a tick whenever the result slot is free or draining
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign step       = in_valid_i & in_ready_o;

  bdlp_debounce u_debounce (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .sample_i          (pin_level_i),
    .pressed_level_i   (pressed_level_q),
    .long_press_ticks_i(long_press_ticks_q),
    .watch_upd_i       (watch_upd),
    .outcome_o         (outcome)
  );

  bdlp_fsm u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .outcome_i       (outcome),
    .release_enable_i(release_enable_q),
    .watch_upd_o     (watch_upd),
    .event_o         (event_d),
    .duration_o      (duration_d),
    .pressed_o       (pressed_d)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (step) begin
      event_code_q     <= event_d;
      press_duration_q <= duration_d;
      is_pressed_q     <= pressed_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_code_o     = event_code_q;
  assign press_duration_o = press_duration_q;
  assign is_pressed_o     = is_pressed_q;

endmodule

`default_nettype wire

// File: rtl/bdlp_checker.sv
// port-level checks for the button debouncer top level, attached by bind
// depends on bdlp_pkg and button_debounce_long_press_top
`timescale 1ns / 1ps
`default_nettype none

module bdlp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] event_code_o,
  input wire logic [7:0] press_duration_o,
  input wire logic       is_pressed_o
);

  // a stalled result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o)
      && $stable(press_duration_o) && $stable(is_pressed_o))
    else $error("stalled result changed");

  // input backpressure only while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // duration only accompanies a release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o != bdlp_pkg::EV_RELEASED |-> press_duration_o == 8'd0)
    else $error("duration without release event");

  // press and long press leave the machine pressed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_code_o == bdlp_pkg::EV_PRESSED || event_code_o == bdlp_pkg::EV_LONG)
      |-> is_pressed_o)
    else $error("press event without pressed state");

  // release leaves the machine released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o == bdlp_pkg::EV_RELEASED |-> !is_pressed_o)
    else $error("release event with pressed state");

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .event_code_o    (event_code_o),
  .press_duration_o(press_duration_o),
  .is_pressed_o    (is_pressed_o)
);

`default_nettype wire

// File: test/tb.sv
// testbench for button_debounce_long_press_top: debounce, press, release and long-press events
// predicts every result from its own model of the debouncer and checks them in order
// depends on bdlp_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_TICKS    = 2000;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_WAIT     = 4;
  localparam int DRAIN_LIMIT     = 1000;

  // index with no register behind it, writes must be ignored
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  // clean press, bounce, confirm, hold, release, abandon while released,
  // press then abandon while pressed, msb first
  localparam logic [23:0] DIRECTED_TICKS = 24'b1_0100000_000_111111_011111_1;

  typedef struct {
    bdlp_pkg::event_e code;
    logic [7:0]       duration;
    logic             pressed;
  } button_event_t;

  // mirror of the debouncer and press state machine plus the queue of results it predicts
  class button_event_checker;
    logic          pressed_level;
    logic          release_en;
    logic [7:0]    long_ticks;
    logic          in_pressed;
    logic          watch_level;
    logic          settled;
    logic          last_sample;
    logic [7:0]    active_run;
    logic [7:0]    inactive_run;
    logic [7:0]    held_ticks;
    button_event_t expected_events[$];
    int unsigned   failures;

    function new();
      pressed_level = 1'b0;
      release_en    = 1'b1;
      long_ticks    = 8'd0;
      in_pressed    = 1'b0;
      watch_level   = 1'b0;
      settled       = 1'b1;
      last_sample   = 1'b1;
      active_run    = 8'd0;
      inactive_run  = 8'd0;
      held_ticks    = 8'd0;
      failures      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        bdlp_pkg::CFG_PRESSED_LEVEL:    pressed_level = data[0];
        bdlp_pkg::CFG_RELEASE_ENABLE:   release_en    = data[0];
        bdlp_pkg::CFG_LONG_PRESS_TICKS: long_ticks    = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] bump(logic [7:0] v);
      return (v == bdlp_pkg::COUNT_MAX) ? v : v + 8'd1;
    endfunction

    // one accepted tick: advance the model and queue the result it causes
    function void note_tick(logic sample);
      bdlp_pkg::outcome_e oc;
      button_event_t      ev;
      oc          = bdlp_pkg::OC_QUIET;
      ev.code     = bdlp_pkg::EV_NONE;
      ev.duration = 8'd0;
      if (settled) begin
        if (sample == watch_level && last_sample != watch_level) begin
          oc           = bdlp_pkg::OC_EDGE;
          active_run   = 8'd0;
          inactive_run = 8'd0;
          settled      = 1'b0;
        end else if (sample != watch_level && watch_level != pressed_level) begin
          // steady hold counts toward long press
          inactive_run = 8'd0;
          active_run   = bump(active_run);
          if (long_ticks != 8'd0 && active_run >= long_ticks) begin
            active_run = 8'd0;
            oc         = bdlp_pkg::OC_LONG;
          end
        end
      end else if (sample == watch_level) begin
        inactive_run = 8'd0;
        active_run   = bump(active_run);
        if (active_run >= bdlp_pkg::SETTLE_ACTIVE_TICKS) begin
          settled = 1'b1;
          oc      = bdlp_pkg::OC_CONFIRM;
        end
      end else begin
        active_run   = 8'd0;
        inactive_run = bump(inactive_run);
        if (inactive_run >= bdlp_pkg::SETTLE_INACTIVE_TICKS) begin
          settled = 1'b1;
          oc      = bdlp_pkg::OC_ABANDON;
        end
      end
      last_sample = sample;

      if (!in_pressed) begin
        // outcomes other than an edge give no event while released
        if (oc == bdlp_pkg::OC_EDGE) begin
          ev.code    = bdlp_pkg::EV_PRESSED;
          held_ticks = 8'd0;
          in_pressed = 1'b1;
        end
      end else begin
        case (oc)
          bdlp_pkg::OC_QUIET:   held_ticks = bump(held_ticks);
          bdlp_pkg::OC_CONFIRM: watch_level = ~watch_level;
          bdlp_pkg::OC_ABANDON: begin
            watch_level = pressed_level;
            in_pressed  = 1'b0;
          end
          bdlp_pkg::OC_EDGE: begin
            if (release_en) begin
              ev.code     = bdlp_pkg::EV_RELEASED;
              ev.duration = held_ticks;
            end
            watch_level = pressed_level;
            in_pressed  = 1'b0;
          end
          bdlp_pkg::OC_LONG:    ev.code = bdlp_pkg::EV_LONG;
          default: ;
        endcase
      end
      ev.pressed = in_pressed;
      expected_events.push_back(ev);
    endfunction

    function void check_result(logic [1:0] code, logic [7:0] duration, logic pressed);
      button_event_t want;
      if (expected_events.size() == 0) begin
        $error("result with no tick waiting: event_code %0d", code);
        failures++;
        return;
      end
      want = expected_events.pop_front();
      if (code !== want.code) begin
        $error("event_code: expected %0d, actual %0d", want.code, code);
        failures++;
      end
      if (duration !== want.duration) begin
        $error("press_duration: expected %0d, actual %0d", want.duration, duration);
        failures++;
      end
      if (pressed !== want.pressed) begin
        $error("is_pressed: expected %0d, actual %0d", want.pressed, pressed);
        failures++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       pin_level_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [1:0] event_code_o;
  logic [7:0] press_duration_o;
  logic       is_pressed_o;

  button_event_checker events_sb;
  int unsigned         cycle_count = 0;
  int unsigned         sent_ticks = 0;
  bit                  no_idle = 1'b0;
  bit                  hold_off_req = 1'b0;
  logic                cur_pressed_level = 1'b0;

  button_debounce_long_press_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pin_level_i      (pin_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_code_o     (event_code_o),
    .press_duration_o (press_duration_o),
    .is_pressed_o     (is_pressed_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("button_debounce_long_press_top test failed");
      $finish;
    end
  end

  // monitor: check the finished transaction first, then predict the new one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        events_sb.check_result(event_code_o, press_duration_o, is_pressed_o);
      end
      if (in_valid_i && in_ready_o) begin
        events_sb.note_tick(pin_level_i);
      end
    end
  end

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // press hold lengths: mostly short, some medium, rarely past saturation
  function automatic int pick_hold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 20);
    end else if (r < 97) begin
      return $urandom_range(20, 80);
    end
    return $urandom_range(250, 300);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall = pick_gap();
        end
      end
    end
  end

  // offer one tick and wait for its transaction; valid drops only across a gap
  task automatic send_tick(input logic level);
    int gap;
    in_valid_i  <= 1'b1;
    pin_level_i <= level;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_ticks++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic hold_level(input logic level, input int n);
    repeat (n) send_tick(level);
  endtask

  task automatic bounce(input int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)));
  endtask

  // bouncy press, steady hold, bouncy release, steady release
  task automatic press_cycle(input int hold);
    bounce($urandom_range(0, 4));
    hold_level(cur_pressed_level, hold);
    bounce($urandom_range(0, 4));
    hold_level(~cur_pressed_level, $urandom_range(1, 15));
  endtask

  // stop offering until every predicted result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (events_sb.expected_events.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    events_sb.write_reg(idx, data);
  endtask

  // 1-bit registers get random upper bits to show they are masked off
  task automatic set_config(input logic level, input logic rel_en, input logic [7:0] ticks);
    write_reg(bdlp_pkg::CFG_PRESSED_LEVEL, {7'($urandom), level});
    write_reg(bdlp_pkg::CFG_RELEASE_ENABLE, {7'($urandom), rel_en});
    write_reg(bdlp_pkg::CFG_LONG_PRESS_TICKS, ticks);
    write_reg(CFG_SPARE_IDX, 8'($urandom));
    cfg_we_i <= 1'b0;
    cur_pressed_level = level;
  endtask

  initial begin
    int         budget;
    int         waited;
    logic       level;
    logic       rel_en;
    logic [7:0] ticks;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = bdlp_pkg::CFG_PRESSED_LEVEL;
    cfg_data_i  = 8'd0;
    in_valid_i  = 1'b0;
    pin_level_i = 1'b0;
    out_ready_i = 1'b0;
    events_sb   = new();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks under the reset configuration
    for (int i = 23; i >= 0; i--) begin
      send_tick(DIRECTED_TICKS[i]);
    end

    // phases of random ticks, each under its own configuration; the state is
    // left as it is between phases, so a polarity change can land mid-press
    budget = RANDOM_TICKS / NUM_PHASES;
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0: begin level = 1'b1; rel_en = 1'b1; ticks = 8'd3;   end
        1: begin level = 1'b0; rel_en = 1'b0; ticks = 8'd1;   end
        2: begin level = 1'b1; rel_en = 1'b0; ticks = 8'd255; end
        3: begin level = 1'b0; rel_en = 1'b1; ticks = 8'd0;   end
        default: begin
          level  = 1'($urandom_range(0, 1));
          rel_en = 1'($urandom_range(0, 1));
          ticks  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
        end
      endcase
      set_config(level, rel_en, ticks);
      no_idle = (p == 5);
      // long stall on the result side while ticks keep coming
      if (p == 2) begin
        hold_off_req = 1'b1;
      end
      // holds past saturation: long press at its maximum, then with long press off
      if (p == 2 || p == 3) begin
        press_cycle($urandom_range(260, 300));
      end
      sent_ticks = 0;
      while (sent_ticks < budget) begin
        if ($urandom_range(0, 3) != 0) begin
          press_cycle(pick_hold());
        end else begin
          bounce($urandom_range(1, 10));
        end
      end
    end
    no_idle = 1'b0;

    // wind down: wait for the last results, bounded
    in_valid_i <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (events_sb.expected_events.size() != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_WAIT) @(posedge clk_i);
    if (events_sb.expected_events.size() != 0) begin
      $error("%0d results never arrived", events_sb.expected_events.size());
      events_sb.failures++;
    end

    if (events_sb.failures == 0) begin
      $display("button_debounce_long_press_top test passed");
    end else begin
      $display("button_debounce_long_press_top test failed");
    end
    $finish;
  end

endmodule
